@@ rtl/trpd_pkg.sv @@
// Shared types, constants and the debounce event update for the touch region press debouncer.
`default_nettype none

package trpd_pkg;

	localparam int unsigned TIME_W   = 48;
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned CENTER_W = 13;
	localparam int unsigned RADIUS_W = 12;
	localparam int unsigned RECT_W   = 13;
	localparam int unsigned DEB_W    = 16;
	localparam int unsigned DUS_W    = 26;
	localparam int unsigned RSQ_W    = 2 * RADIUS_W;
	localparam int unsigned CFG_W    = 16;

	localparam logic [9:0] US_PER_MS = 10'd1000;

	typedef enum logic [2:0] {
		REG_CENTER_X     = 3'd0,
		REG_CENTER_Y     = 3'd1,
		REG_SHAPE_CIRCLE = 3'd2,
		REG_RADIUS       = 3'd3,
		REG_RECT_WIDTH   = 3'd4,
		REG_RECT_HEIGHT  = 3'd5,
		REG_DEBOUNCE_MS  = 3'd6,
		REG_TOUCH_ENABLE = 3'd7
	} cfg_reg_t;

	// region geometry handed to the hit test
	typedef struct packed {
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic                       shape_circle;
		logic [RSQ_W-1:0]           radius_sq;
		logic [RECT_W-1:0]          rect_width;
		logic [RECT_W-1:0]          rect_height;
	} region_t;

	// second pipeline stage: sample reduced to a hit bit
	typedef struct packed {
		logic [TIME_W-1:0] now_us;
		logic              pen_down;
		logic              hit;
		logic              ack_press;
		logic              ack_release;
		logic              ack_press_outside;
	} hit_word_t;

	typedef struct packed {
		logic              touched;
		logic              outside;
		logic              press_active;
		logic              press_acked;
		logic              press_debouncing;
		logic [TIME_W-1:0] press_deadline;
		logic              release_active;
		logic              release_acked;
		logic              release_debouncing;
		logic [TIME_W-1:0] release_deadline;
		logic              outside_active;
		logic              outside_acked;
		logic              outside_debouncing;
		logic [TIME_W-1:0] outside_deadline;
	} ev_state_t;

	// one pass of the press / release / press-outside timers; dl is now plus debounce, saturated
	function automatic ev_state_t trpd_run_events(ev_state_t cur, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] dl);
		ev_state_t s;
		s = cur;
		if (!s.press_active && s.touched && !s.press_debouncing) begin
			s.press_debouncing = 1'b1;
			s.press_active     = 1'b1;
			s.press_acked      = 1'b0;
			s.press_deadline   = dl;
		end
		if (s.press_debouncing && (now >= s.press_deadline) && !s.touched) begin
			s.press_active       = 1'b0;
			s.press_debouncing   = 1'b0;
			s.release_active     = 1'b1;
			s.release_deadline   = dl;
			s.release_debouncing = 1'b1;
			s.release_acked      = 1'b0;
		end
		if (s.release_debouncing && (now >= s.release_deadline)) begin
			s.release_active     = 1'b0;
			s.release_debouncing = 1'b0;
		end
		if (s.press_active && s.press_acked) s.press_active = 1'b0;
		if (s.release_active && s.release_acked) s.release_active = 1'b0;
		if (!s.outside_active && s.outside && !s.outside_debouncing) begin
			s.outside_debouncing = 1'b1;
			s.outside_active     = 1'b1;
			s.outside_acked      = 1'b0;
			s.outside_deadline   = dl;
		end
		if (s.outside_debouncing && (now >= s.outside_deadline)) begin
			s.outside_active     = 1'b0;
			s.outside_debouncing = 1'b0;
		end
		if (s.outside_active && s.outside_acked) s.outside_active = 1'b0;
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/touch_region_press_debouncer.sv @@
// Touch region press debouncer: three-stage sample pipeline with debounced event timers.
// An accepted word passes the stage 1 and stage 2 registers into the result register.
// Throughput: one word per cycle while out_stall is low; stage 1 registers the sample,
// stage 2 the hit test, stage 3 updates the flags and deadlines and holds the result until taken.
// Each stage refills as soon as its word moves on; input stalls only when all three are full and out_stall is high.
// Reset clears the valid flags, configuration and event state; the first-sample flag comes up set.
`default_nettype none

module touch_region_press_debouncer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [trpd_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [trpd_pkg::TIME_W-1:0]     now_us,
	input  wire logic                            pen_down,
	input  wire logic [trpd_pkg::COORD_W-1:0]    touch_x,
	input  wire logic [trpd_pkg::COORD_W-1:0]    touch_y,
	input  wire logic                            ack_press,
	input  wire logic                            ack_release,
	input  wire logic                            ack_press_outside,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 is_touched,
	output logic                                 is_touched_outside,
	output logic                                 press_event,
	output logic                                 release_event,
	output logic                                 press_outside_event
);
	import trpd_pkg::*;

	// configuration
	region_t            region_q;
	logic [DUS_W-1:0]   debounce_us_q;
	logic               touch_enable_q;
	logic               first_sample_q;
	cfg_reg_t           cfg_sel;

	// pipeline
	logic                 s1_valid_q, s2_valid_q, out_valid_q;
	logic [TIME_W-1:0]    now_s1;
	logic                 pen_s1, ack_p_s1, ack_r_s1, ack_o_s1;
	logic [COORD_W-1:0]   x_s1, y_s1;
	hit_word_t            word_s2;
	logic                 hit_s1;
	logic                 en_s1, en_s2, en_out, step;

	// event state
	ev_state_t            ev_q, ev_nxt;
	logic [TIME_W:0]      dl_sum;
	logic [TIME_W-1:0]    dl;
	logic [4:0]           res_q;

	assign cfg_sel = cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q       <= '0;
			debounce_us_q  <= '0;
			touch_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_sel)
				REG_CENTER_X:     region_q.center_x <= signed'(cfg_data[CENTER_W-1:0]);
				REG_CENTER_Y:     region_q.center_y <= signed'(cfg_data[CENTER_W-1:0]);
				REG_SHAPE_CIRCLE: region_q.shape_circle <= cfg_data[0];
				REG_RADIUS:       region_q.radius_sq <= RSQ_W'(cfg_data[RADIUS_W-1:0])
				                                        * RSQ_W'(cfg_data[RADIUS_W-1:0]);
				REG_RECT_WIDTH:   region_q.rect_width <= cfg_data[RECT_W-1:0];
				REG_RECT_HEIGHT:  region_q.rect_height <= cfg_data[RECT_W-1:0];
				REG_DEBOUNCE_MS:  debounce_us_q <= DUS_W'(cfg_data) * DUS_W'(US_PER_MS);
				REG_TOUCH_ENABLE: touch_enable_q <= cfg_data[0];
				default:          touch_enable_q <= touch_enable_q;
			endcase
		end
	end

	// per-stage enables: a stage loads when empty or when its word moves on
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s2    = !s2_valid_q || en_out;
	assign en_s1    = !s1_valid_q || en_s2;
	assign in_stall = !en_s1;
	assign step     = s2_valid_q && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) s1_valid_q <= in_valid;
			if (en_s2) s2_valid_q <= s1_valid_q;
			if (en_out) out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			now_s1   <= now_us;
			pen_s1   <= pen_down;
			x_s1     <= touch_x;
			y_s1     <= touch_y;
			ack_p_s1 <= ack_press;
			ack_r_s1 <= ack_release;
			ack_o_s1 <= ack_press_outside;
		end
		if (s1_valid_q && en_s2) begin
			word_s2.now_us            <= now_s1;
			word_s2.pen_down          <= pen_s1;
			word_s2.hit               <= hit_s1;
			word_s2.ack_press         <= ack_p_s1;
			word_s2.ack_release       <= ack_r_s1;
			word_s2.ack_press_outside <= ack_o_s1;
		end
	end

	trpd_hit u_hit (
		.x      (x_s1),
		.y      (y_s1),
		.region (region_q),
		.hit    (hit_s1)
	);

	// stage 3: acks, flag update, two event passes on the first sample
	always_comb begin
		ev_nxt = ev_q;
		dl_sum = {1'b0, word_s2.now_us} + (TIME_W+1)'(debounce_us_q);
		dl     = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
		if (word_s2.ack_press && ev_nxt.press_active) ev_nxt.press_acked = 1'b1;
		if (word_s2.ack_release && ev_nxt.release_active) ev_nxt.release_acked = 1'b1;
		if (word_s2.ack_press_outside && ev_nxt.outside_active) ev_nxt.outside_acked = 1'b1;
		if (touch_enable_q) begin
			if (!word_s2.pen_down) begin
				ev_nxt.touched = 1'b0;
				ev_nxt.outside = 1'b0;
			end else if (word_s2.hit) begin
				ev_nxt.touched = 1'b1;
			end else begin
				ev_nxt.touched = 1'b0;
				ev_nxt.outside = 1'b1;
			end
		end
		ev_nxt = trpd_run_events(ev_nxt, word_s2.now_us, dl);
		if (first_sample_q) begin
			if (ev_nxt.press_active) ev_nxt.press_acked = 1'b1;
			if (ev_nxt.release_active) ev_nxt.release_acked = 1'b1;
			ev_nxt = trpd_run_events(ev_nxt, word_s2.now_us, dl);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q           <= '0;
			first_sample_q <= 1'b1;
		end else begin
			if (step) ev_q <= ev_nxt;
			if (cfg_wr_en && cfg_sel == REG_TOUCH_ENABLE && cfg_data[0]) begin
				first_sample_q <= 1'b1;
			end else if (step) begin
				first_sample_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= {ev_nxt.touched, ev_nxt.outside, ev_nxt.press_active,
			          ev_nxt.release_active, ev_nxt.outside_active};
		end
	end

	assign out_valid           = out_valid_q;
	assign is_touched          = res_q[4];
	assign is_touched_outside  = res_q[3];
	assign press_event         = res_q[2];
	assign release_event       = res_q[1];
	assign press_outside_event = res_q[0];

	a_press_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q.press_active |-> ev_q.press_debouncing)
		else $error("press active without its debounce timer");

	a_release_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q.release_active |-> ev_q.release_debouncing)
		else $error("release active without its debounce timer");

	a_outside_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q.outside_active |-> ev_q.outside_debouncing)
		else $error("press-outside active without its debounce timer");

	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with empty result register");

	a_first_sample_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cfg_wr_en) |=> !first_sample_q)
		else $error("first-sample flag survived a processed word");

endmodule

`default_nettype wire

@@ rtl/trpd_hit.sv @@
// Hit test of one touch point against a rectangle or circle region.
`default_nettype none

module trpd_hit (
	input  wire logic [trpd_pkg::COORD_W-1:0] x,
	input  wire logic [trpd_pkg::COORD_W-1:0] y,
	input  wire trpd_pkg::region_t            region,
	output logic                              hit
);
	import trpd_pkg::*;

	logic signed [14:0] xs, ys, cx, cy, hw, hh;
	logic signed [14:0] dx, dy;
	logic signed [29:0] dx2, dy2;
	logic signed [30:0] dist_sq;
	logic               in_rect, in_circle;

	always_comb begin
		xs = signed'({3'b000, x});
		ys = signed'({3'b000, y});
		cx = 15'(region.center_x);
		cy = 15'(region.center_y);
		// half sizes truncate
		hw = signed'({3'b000, region.rect_width[RECT_W-1:1]});
		hh = signed'({3'b000, region.rect_height[RECT_W-1:1]});
		dx = xs - cx;
		dy = ys - cy;
		dx2 = 30'(dx) * 30'(dx);
		dy2 = 30'(dy) * 30'(dy);
		dist_sq = 31'(dx2) + 31'(dy2);
		in_rect = (xs >= cx - hw) && (xs <= cx + hw) && (ys >= cy - hh) && (ys <= cy + hh);
		in_circle = dist_sq <= signed'({7'd0, region.radius_sq});
		hit = region.shape_circle ? in_circle : in_rect;
	end

endmodule

`default_nettype wire
